// ===== hdl/ufr_pkg.sv =====
// ----------------------------------------------------------------------------
// ufr_pkg
// Shared types and constants for the uart frame receiver: field widths,
// register indexes and reset values, replay sequencer states.
// ----------------------------------------------------------------------------
package ufr_pkg;

  // field widths
  localparam int BYTE_W = 8;
  localparam int POS_W  = 5;
  localparam int IDX_W  = 9;
  localparam int CFG_AW = 1;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_HEAD = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_TAIL = 1'b1;

  // register reset values
  localparam logic [BYTE_W-1:0] HEAD_RESET = 8'hAA;
  localparam logic [BYTE_W-1:0] TAIL_RESET = 8'h55;

  // frame byte counter saturates here
  localparam logic [IDX_W-1:0] IDX_MAX = 9'h1FF;

  // mask for the running payload sum low bit
  localparam logic [BYTE_W-1:0] PARITY_MASK = 8'h01;

  // replay sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SHOW
  } rep_state_t;

  // captured frame header and check data, parser to replay
  typedef struct packed {
    logic [BYTE_W-1:0] id;
    logic [BYTE_W-1:0] length;
    logic [BYTE_W-1:0] check;
    logic              parity;
  } frame_info_t;

endpackage

// ===== hdl/ufr_ifs.sv =====
// ----------------------------------------------------------------------------
// ufr_ifs
// Valid/ready channel interfaces: received bytes in, replayed frame results
// out.
// ----------------------------------------------------------------------------
interface ufr_in_if;
  logic                      valid;
  logic                      ready;
  logic [ufr_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ufr_out_if;
  logic                      valid;
  logic                      ready;
  logic [ufr_pkg::BYTE_W-1:0] msg_id;
  logic [ufr_pkg::BYTE_W-1:0] frame_length;
  logic [ufr_pkg::BYTE_W-1:0] payload_byte;
  logic [ufr_pkg::POS_W-1:0]  position;
  logic                      has_payload;
  logic                      last;
  logic                      check_match;
  logic                      truncated;

  modport source (output valid, output msg_id, output frame_length,
                  output payload_byte, output position, output has_payload,
                  output last, output check_match, output truncated,
                  input ready);
  modport sink   (input valid, input msg_id, input frame_length,
                  input payload_byte, input position, input has_payload,
                  input last, input check_match, input truncated,
                  output ready);
endinterface

// ===== hdl/ufr_parser.sv =====
// ----------------------------------------------------------------------------
// ufr_parser
// Frame parser: holds the head/tail registers, tracks the position inside a
// frame, captures id, length, check and payload parity, and issues payload
// store writes. Signals a tail so the replay sequencer can start.
// ----------------------------------------------------------------------------
module ufr_parser #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [ufr_pkg::CFG_AW-1:0]             cfg_addr,
  input  logic [ufr_pkg::BYTE_W-1:0]             cfg_wdata,
  input  logic                                   byte_req,
  input  logic [ufr_pkg::BYTE_W-1:0]             byte_in,
  output logic                                   tail_fire,
  output ufr_pkg::frame_info_t                   info,
  output logic                                   wr_en,
  output logic [((MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1)-1:0] wr_addr,
  output logic [ufr_pkg::BYTE_W-1:0]             wr_data
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [ufr_pkg::BYTE_W-1:0] head_r, head_nxt;
  logic [ufr_pkg::BYTE_W-1:0] tail_r, tail_nxt;
  logic                       in_frame_r, in_frame_nxt;
  logic [ufr_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  ufr_pkg::frame_info_t       info_r, info_nxt;

  logic [ufr_pkg::IDX_W:0]    idx_ext;
  logic [ufr_pkg::IDX_W:0]    len_p2;
  logic [ufr_pkg::IDX_W:0]    len_p3;
  logic [ufr_pkg::IDX_W-1:0]  pos;

  // configuration registers
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        ufr_pkg::CFG_HEAD: head_nxt = cfg_wdata;
        ufr_pkg::CFG_TAIL: tail_nxt = cfg_wdata;
        default:           head_nxt = head_r;
      endcase
    end
  end

  // frame position compares
  assign idx_ext = {1'b0, idx_r};
  assign len_p2  = (ufr_pkg::IDX_W + 1)'(info_r.length) + (ufr_pkg::IDX_W + 1)'(2);
  assign len_p3  = (ufr_pkg::IDX_W + 1)'(info_r.length) + (ufr_pkg::IDX_W + 1)'(3);
  assign pos     = idx_r - ufr_pkg::IDX_W'(2);

  // byte classification and capture
  always_comb begin
    in_frame_nxt = in_frame_r;
    idx_nxt      = idx_r;
    info_nxt     = info_r;
    tail_fire    = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = pos[AW-1:0];
    wr_data      = byte_in;
    if (byte_req) begin
      priority if (!in_frame_r) begin
        if (byte_in == head_r) begin
          in_frame_nxt    = 1'b1;
          idx_nxt         = '0;
          info_nxt.parity = 1'b0;
        end
      end else if (byte_in == tail_r) begin
        in_frame_nxt = 1'b0;
        tail_fire    = 1'b1;
      end else begin
        priority if (idx_r == ufr_pkg::IDX_W'(0)) begin
          info_nxt.id = byte_in;
        end else if (idx_r == ufr_pkg::IDX_W'(1)) begin
          info_nxt.length = byte_in;
        end else if (idx_ext < len_p2) begin
          wr_en           = ({1'b0, pos} < (ufr_pkg::IDX_W + 1)'(MAX_PAYLOAD));
          info_nxt.parity = info_r.parity ^ (|(byte_in & ufr_pkg::PARITY_MASK));
        end else if (idx_ext == len_p2) begin
          info_nxt.check = byte_in;
        end else if (idx_ext > len_p3) begin
          in_frame_nxt = 1'b0;
        end else begin
          info_nxt = info_r;
        end
        if (idx_r != ufr_pkg::IDX_MAX) begin
          idx_nxt = idx_r + ufr_pkg::IDX_W'(1);
        end
      end
    end
  end

  assign info = info_r;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= ufr_pkg::HEAD_RESET;
      tail_r     <= ufr_pkg::TAIL_RESET;
      in_frame_r <= 1'b0;
      idx_r      <= '0;
      info_r     <= '0;
    end else begin
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      in_frame_r <= in_frame_nxt;
      idx_r      <= idx_nxt;
      info_r     <= info_nxt;
    end
  end

endmodule

// ===== hdl/ufr_store.sv =====
// ----------------------------------------------------------------------------
// ufr_store
// Payload store: one write port, one registered read port. A valid bit per
// entry, cleared at reset, makes never-written entries read as zero.
// ----------------------------------------------------------------------------
module ufr_store #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   wr_en,
  input  logic [((MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1)-1:0] wr_addr,
  input  logic [ufr_pkg::BYTE_W-1:0]             wr_data,
  input  logic                                   rd_en,
  input  logic [((MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1)-1:0] rd_addr,
  output logic [ufr_pkg::BYTE_W-1:0]             rd_data
);

  logic [ufr_pkg::BYTE_W-1:0] mem [MAX_PAYLOAD];
  logic [MAX_PAYLOAD-1:0]     valid_r;
  logic [ufr_pkg::BYTE_W-1:0] rdata_r;
  logic                       rvalid_r;

  // storage array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // entry valid bits and registered read valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvalid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rvalid_r ? rdata_r : '0;

endmodule

// ===== hdl/ufr_replay.sv =====
// ----------------------------------------------------------------------------
// ufr_replay
// Replay sequencer: after a tail, steps one counter through the stored
// payload, reading one entry and presenting one result at a time.
// ----------------------------------------------------------------------------
module ufr_replay #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   tail_fire,
  input  ufr_pkg::frame_info_t                   info,
  output logic                                   idle,
  output logic                                   rd_en,
  output logic [((MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1)-1:0] rd_addr,
  input  logic [ufr_pkg::BYTE_W-1:0]             rd_data,
  ufr_out_if.source                              out_res
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CW = $clog2(MAX_PAYLOAD + 1);

  ufr_pkg::rep_state_t state_r, state_nxt;
  logic [CW-1:0]       k_r, k_nxt;
  logic [CW-1:0]       n_r, n_nxt;
  logic                has_r, has_nxt;

  logic                trunc;
  logic [CW-1:0]       n_frame;
  logic                last;
  logic [CW+ufr_pkg::POS_W-1:0] k_ext;

  // payload count for this frame, clipped to the store size
  assign trunc   = ({1'b0, info.length} > (ufr_pkg::BYTE_W + 1)'(MAX_PAYLOAD));
  assign n_frame = trunc ? CW'(MAX_PAYLOAD) : CW'(info.length);
  assign last    = !has_r || ((k_r + CW'(1)) == n_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    n_nxt     = n_r;
    has_nxt   = has_r;
    unique case (state_r)
      ufr_pkg::ST_IDLE: begin
        if (tail_fire) begin
          k_nxt   = '0;
          n_nxt   = n_frame;
          has_nxt = (n_frame != '0);
          state_nxt = (n_frame != '0) ? ufr_pkg::ST_READ : ufr_pkg::ST_SHOW;
        end
      end
      ufr_pkg::ST_READ: begin
        state_nxt = ufr_pkg::ST_SHOW;
      end
      ufr_pkg::ST_SHOW: begin
        if (out_res.ready) begin
          if (last) begin
            state_nxt = ufr_pkg::ST_IDLE;
          end else begin
            k_nxt     = k_r + CW'(1);
            state_nxt = ufr_pkg::ST_READ;
          end
        end
      end
      default: state_nxt = ufr_pkg::ST_IDLE;
    endcase
  end

  // outputs
  assign k_ext = (CW + ufr_pkg::POS_W)'(k_r);

  always_comb begin
    idle    = (state_r == ufr_pkg::ST_IDLE);
    rd_en   = (state_r == ufr_pkg::ST_READ);
    rd_addr = k_r[AW-1:0];
    out_res.valid        = (state_r == ufr_pkg::ST_SHOW);
    out_res.msg_id       = info.id;
    out_res.frame_length = info.length;
    out_res.payload_byte = has_r ? rd_data : '0;
    out_res.position     = k_ext[ufr_pkg::POS_W-1:0];
    out_res.has_payload  = has_r;
    out_res.last         = last;
    out_res.check_match  = (info.check == {{(ufr_pkg::BYTE_W-1){1'b0}}, info.parity});
    out_res.truncated    = trunc;
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ufr_pkg::ST_IDLE;
      k_r     <= '0;
      n_r     <= '0;
      has_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      n_r     <= n_nxt;
      has_r   <= has_nxt;
    end
  end

endmodule

// ===== hdl/uart_frame_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// uart_frame_receiver_unit
// Deframes received UART bytes (head, id, length, payload, check, tail) and
// replays each closed frame as one result per stored payload byte, or as a single result for an empty frame.
// ----------------------------------------------------------------------------
// Usage: while no replay is running the block takes one byte request per
// cycle. A tail byte starts a replay during which in_rx.ready is low: each
// payload result takes one read of the payload store, then the result is
// held until taken, so the block takes no new byte until the whole frame
// has been replayed; the single read port of the store sets this pace. The
// store keeps a valid bit per entry, so no clearing pass follows reset.
// Head and tail bytes are set through the cfg_ port (index 0 head, index 1
// tail) by the user, only while the block is idle; the block leaves this unchecked.
module uart_frame_receiver_unit #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [ufr_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [ufr_pkg::BYTE_W-1:0] cfg_wdata,
  ufr_in_if.sink                     in_rx,
  ufr_out_if.source                  out_res
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic                       rep_idle;
  logic                       byte_req;
  logic                       tail_fire;
  ufr_pkg::frame_info_t       info;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [ufr_pkg::BYTE_W-1:0] wr_data;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic [ufr_pkg::BYTE_W-1:0] rd_data;

  // input handshake
  assign in_rx.ready = rep_idle;
  assign byte_req    = in_rx.valid && rep_idle;

  ufr_parser #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .byte_req  (byte_req),
    .byte_in   (in_rx.rx_byte),
    .tail_fire (tail_fire),
    .info      (info),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  ufr_store #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ufr_replay #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_replay (
    .clk       (clk),
    .rst_n     (rst_n),
    .tail_fire (tail_fire),
    .info      (info),
    .idle      (rep_idle),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_res   (out_res)
  );

endmodule

// ===== verif/ufr_replay_check_pkg.sv =====
// ----------------------------------------------------------------------------
// ufr_replay_check_pkg
// Frame replay predictor and scoreboard for the uart frame receiver. It
// follows the deframing of every accepted byte and queues the results that a
// closing tail must replay. Results taken from the block are matched against
// that queue one field at a time.
// ----------------------------------------------------------------------------
package ufr_replay_check_pkg;
  import ufr_pkg::*;

  localparam int PAYLOAD_SLOTS = 32;
  localparam int MAX_REPORTS   = 100;

  // one replayed result as the block presents it
  typedef struct packed {
    logic [BYTE_W-1:0] msg_id;
    logic [BYTE_W-1:0] frame_length;
    logic [BYTE_W-1:0] payload_byte;
    logic [POS_W-1:0]  position;
    logic              has_payload;
    logic              last;
    logic              check_match;
    logic              truncated;
  } replay_item_t;

  class frame_replay_board;
    // register copies
    logic [BYTE_W-1:0] head_val;
    logic [BYTE_W-1:0] tail_val;

    // deframer state
    bit                in_frame;
    logic [IDX_W-1:0]  byte_idx;
    logic [BYTE_W-1:0] frm_id;
    logic [BYTE_W-1:0] frm_len;
    logic [BYTE_W-1:0] frm_check;
    bit                sum_bit;
    logic [BYTE_W-1:0] slots [PAYLOAD_SLOTS];

    replay_item_t      expected_replay [$];

    int mismatches;
    int bytes_seen;
    int results_seen;
    int frames_replayed;
    int truncated_frames;
    int empty_frames;

    function new();
      head_val  = HEAD_RESET;
      tail_val  = TAIL_RESET;
      in_frame  = 1'b0;
      byte_idx  = '0;
      frm_id    = '0;
      frm_len   = '0;
      frm_check = '0;
      sum_bit   = 1'b0;
      foreach (slots[i]) slots[i] = '0;
      mismatches       = 0;
      bytes_seen       = 0;
      results_seen     = 0;
      frames_replayed  = 0;
      truncated_frames = 0;
      empty_frames     = 0;
    endfunction

    function void write_reg(logic [CFG_AW-1:0] idx, logic [BYTE_W-1:0] v);
      if (idx == CFG_HEAD) head_val = v;
      else if (idx == CFG_TAIL) tail_val = v;
    endfunction

    function int pending();
      return expected_replay.size();
    endfunction

    // advance the deframer by one accepted byte request
    function void note_rx_byte(logic [BYTE_W-1:0] b);
      replay_item_t r;
      int           idx;
      int           len;
      int           n;
      bytes_seen++;
      if (!in_frame) begin
        if (b == head_val) begin
          in_frame = 1'b1;
          byte_idx = '0;
          sum_bit  = 1'b0;
        end
        return;
      end

      // a tail at any position replays what the frame holds now
      if (b == tail_val) begin
        in_frame = 1'b0;
        n = (frm_len > PAYLOAD_SLOTS) ? PAYLOAD_SLOTS : int'(frm_len);
        r.msg_id       = frm_id;
        r.frame_length = frm_len;
        r.check_match  = (frm_check == {7'b0, sum_bit});
        r.truncated    = (frm_len > PAYLOAD_SLOTS);
        if (n == 0) begin
          r.payload_byte = '0;
          r.position     = '0;
          r.has_payload  = 1'b0;
          r.last         = 1'b1;
          expected_replay.push_back(r);
        end else begin
          for (int k = 0; k < n; k++) begin
            r.payload_byte = slots[k];
            r.position     = POS_W'(k);
            r.has_payload  = 1'b1;
            r.last         = (k == n - 1);
            expected_replay.push_back(r);
          end
        end
        return;
      end

      // id, length, payload, check, then at most one spare byte
      idx = int'(byte_idx);
      len = int'(frm_len);
      if (idx == 0) begin
        frm_id = b;
      end else if (idx == 1) begin
        frm_len = b;
      end else if (idx < 2 + len) begin
        if (idx - 2 < PAYLOAD_SLOTS) slots[idx - 2] = b;
        sum_bit ^= b[0];
      end else if (idx == 2 + len) begin
        frm_check = b;
      end else if (idx > 3 + len) begin
        in_frame = 1'b0;
      end
      if (byte_idx != IDX_MAX) byte_idx++;
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task compare_field(string name, logic [BYTE_W-1:0] got, logic [BYTE_W-1:0] want,
                       replay_item_t ref_item);
      if (got !== want)
        report_mismatch($sformatf("%s got %0h, expected %0h (id %0h, position %0d)",
                                  name, got, want, ref_item.msg_id, ref_item.position));
    endtask

    // match one taken result against the oldest expectation
    task check_replay(replay_item_t got);
      replay_item_t want;
      results_seen++;
      if (expected_replay.size() == 0) begin
        report_mismatch($sformatf("result id %0h position %0d with no replay pending",
                                  got.msg_id, got.position));
        return;
      end
      want = expected_replay.pop_front();
      compare_field("msg_id",       got.msg_id,       want.msg_id,       want);
      compare_field("frame_length", got.frame_length, want.frame_length, want);
      compare_field("payload_byte", got.payload_byte, want.payload_byte, want);
      compare_field("position",     BYTE_W'(got.position),
                    BYTE_W'(want.position), want);
      compare_field("has_payload",  BYTE_W'(got.has_payload),
                    BYTE_W'(want.has_payload), want);
      compare_field("last",         BYTE_W'(got.last),
                    BYTE_W'(want.last), want);
      compare_field("check_match",  BYTE_W'(got.check_match),
                    BYTE_W'(want.check_match), want);
      compare_field("truncated",    BYTE_W'(got.truncated),
                    BYTE_W'(want.truncated), want);
      if (want.last) begin
        frames_replayed++;
        if (want.truncated) truncated_frames++;
        if (!want.has_payload) empty_frames++;
      end
    endtask
  endclass

endpackage

// ===== verif/uart_frame_receiver_unit_tb.sv =====
// ----------------------------------------------------------------------------
// uart_frame_receiver_unit_tb
// Self-checking bench for the uart frame receiver. A short directed byte
// stream hits the corner cases, then random frames (well formed, cut short by
// an early tail, dropped, plus idle noise) run under several head/tail
// settings with random gaps, result stalls and one long result hold-off.
// ----------------------------------------------------------------------------
module uart_frame_receiver_unit_tb;
  import ufr_pkg::*;
  import ufr_replay_check_pkg::*;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 16;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [BYTE_W-1:0] cfg_wdata;

  bit idle_en;
  bit hold_req;
  int settings_used;
  int cycle_count;

  frame_replay_board board;

  ufr_in_if  rx_if ();
  ufr_out_if res_if ();

  uart_frame_receiver_unit #(
    .MAX_PAYLOAD(PAYLOAD_SLOTS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .in_rx    (rx_if),
    .out_res  (res_if)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still pending",
             cycle_count, board.pending());
    $display("status: fail");
    $finish;
  end

  // result side ready: random stall bursts and the long hold-off
  initial begin
    res_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 6) - 1) @(negedge clk);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // take results
  always @(posedge clk) begin : take_result
    replay_item_t got;
    if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      got.msg_id       = res_if.msg_id;
      got.frame_length = res_if.frame_length;
      got.payload_byte = res_if.payload_byte;
      got.position     = res_if.position;
      got.has_payload  = res_if.has_payload;
      got.last         = res_if.last;
      got.check_match  = res_if.check_match;
      got.truncated    = res_if.truncated;
      board.check_replay(got);
    end
  end

  // offer one byte request, with an optional gap in front
  task automatic put_byte(logic [BYTE_W-1:0] b);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      rx_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk);
    while (rx_if.ready !== 1'b1) @(posedge clk);
    board.note_rx_byte(b);
  endtask

  task automatic set_reg(logic [CFG_AW-1:0] idx, logic [BYTE_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    board.write_reg(idx, v);
  endtask

  // stop offering, drain every expected result and let the block go quiet
  task automatic settle();
    @(negedge clk);
    rx_if.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [BYTE_W-1:0] not_tail(logic [BYTE_W-1:0] b);
    return (b == board.tail_val) ? b + 8'd1 : b;
  endfunction

  function automatic logic [BYTE_W-1:0] rand_byte();
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // random frames: mostly well formed, some cut short or dropped, some noise
  task automatic random_frames(int n_items);
    logic [BYTE_W-1:0] body [$];
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] len;
    int                sent;
    int                kind;
    int                sel;
    int                cut;
    bit                par;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind == 9) begin
        // noise while idle, never the head
        repeat ($urandom_range(1, 3)) begin
          b = rand_byte();
          if (b == board.head_val) b = ~b;
          put_byte(b);
        end
      end else begin
        body = {};
        body.push_back(not_tail(rand_byte()));
        sel = $urandom_range(0, 9);
        if (sel < 6) len = BYTE_W'($urandom_range(0, 8));
        else if (sel < 8) len = BYTE_W'($urandom_range(9, 32));
        else if (sel == 8) len = BYTE_W'($urandom_range(33, 40));
        else len = BYTE_W'($urandom_range(31, 33));
        len = not_tail(len);
        body.push_back(len);
        par = 1'b0;
        for (int i = 0; i < int'(len); i++) begin
          b = not_tail(rand_byte());
          par ^= b[0];
          body.push_back(b);
        end
        case ($urandom_range(0, 3))
          0, 1:    b = {7'b0, par};
          2:       b = {7'b0, ~par};
          default: b = rand_byte();
        endcase
        body.push_back(not_tail(b));
        if (kind == 8) begin
          // two spare bytes past the check drop the frame
          body.push_back(not_tail(rand_byte()));
          body.push_back(not_tail(rand_byte()));
        end else if (kind < 6 && $urandom_range(0, 3) == 0) begin
          body.push_back(not_tail(rand_byte()));
        end
        if (kind == 6 || kind == 7) cut = $urandom_range(0, body.size() - 1);
        else cut = body.size();
        put_byte(board.head_val);
        for (int i = 0; i < cut; i++) put_byte(body[i]);
        sent += cut + 1;
        if (kind != 8) begin
          put_byte(board.tail_val);
          sent++;
        end
      end
    end
  endtask

  initial begin
    // corner cases under the reset head and tail values
    logic [BYTE_W-1:0] opening [25] = '{
      TAIL_RESET,
      HEAD_RESET, 8'hFF, 8'h00, 8'h00, TAIL_RESET,
      HEAD_RESET, 8'h00, 8'h03, 8'hFF, 8'h01, HEAD_RESET, 8'h00, TAIL_RESET,
      HEAD_RESET, 8'h07, 8'h00, 8'h01, 8'h11, 8'h22,
      HEAD_RESET, 8'h09, 8'hFF, 8'h01, TAIL_RESET
    };
    logic [BYTE_W-1:0] v;

    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_addr       = CFG_HEAD;
    cfg_wdata      = '0;
    rx_if.valid    = 1'b0;
    rx_if.rx_byte  = '0;
    idle_en        = 1'b1;
    hold_req       = 1'b0;
    settings_used  = 1;
    board          = new();

    // reset held, then released on a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset values: directed stream then random frames
    foreach (opening[i]) put_byte(opening[i]);
    random_frames(60);

    // lowest head, highest tail, with the long result hold-off
    settle();
    set_reg(CFG_HEAD, 8'h00);
    set_reg(CFG_TAIL, 8'hFF);
    settings_used++;
    hold_req = 1'b1;
    random_frames(60);

    // highest head, lowest tail
    settle();
    set_reg(CFG_HEAD, 8'hFF);
    set_reg(CFG_TAIL, 8'h00);
    settings_used++;
    random_frames(60);

    // head and tail the same byte
    settle();
    v = rand_byte();
    set_reg(CFG_HEAD, v);
    set_reg(CFG_TAIL, v);
    settings_used++;
    random_frames(50);

    // random pair, no idling on either side
    settle();
    set_reg(CFG_HEAD, rand_byte());
    set_reg(CFG_TAIL, rand_byte());
    settings_used++;
    idle_en = 1'b0;
    random_frames(70);

    settle();
    $display("%0d bytes fed, %0d frames replayed as %0d results (%0d empty, %0d truncated)",
             board.bytes_seen, board.frames_replayed, board.results_seen,
             board.empty_frames, board.truncated_frames);
    $display("%0d head/tail settings used, %0d mismatches", settings_used,
             board.mismatches);
    if (board.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
